[rtl/mpbm_pkg.sv]
// mpbm_pkg: command codes and line decision codes for the multi-pattern byte matcher
// no dependencies
package mpbm_pkg;

  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_PATTERN = 3'd1;
  localparam logic [2:0] CMD_BUILD   = 3'd2;
  localparam logic [2:0] CMD_TEXT    = 3'd3;
  localparam logic [2:0] CMD_EOL     = 3'd4;

  localparam logic [7:0] WORD_END  = 8'd10;
  localparam logic [7:0] BYTE_MASK = 8'hff;

  localparam logic [1:0] UNDECIDED     = 2'd0;
  localparam logic [1:0] DECIDED_MATCH = 2'd1;
  localparam logic [1:0] DECIDED_MISS  = 2'd2;

endpackage

[rtl/mpbm_ram.sv]
// mpbm_ram: simple dual port memory, one write and one registered read per cycle
// no dependencies
module mpbm_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 40,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/multi_pattern_byte_matcher.sv]
// multi_pattern_byte_matcher: line matcher over a trie with failure links
// depends on mpbm_pkg and mpbm_ram (node store and breadth-first queue)
//
//   channel   signals                              direction
//   item      item_valid item_stall cmd byte_value in, stall out
//   result    result_valid result_stall line_match out, stall in
//             table_full
//   config    whole_line_write whole_line          in
//
// each node read passes a read state and a check state on the single node store read port
// a text byte walks sibling and failure chains; build walks every node and its
// failure chain; a pattern byte walks the sibling chain, with an extra write
// state when a sibling edge is added
// reset and clear sweep the node store with item_stall high
// a result waits in the output register while the next item is taken
module multi_pattern_byte_matcher #(
  parameter int NODE_COUNT = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] byte_value,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       line_match,
  output logic       table_full,
  input  logic       whole_line_write,
  input  logic       whole_line
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [AW:0] NODE_CNT = (AW + 1)'(NODE_COUNT);

  typedef struct packed {
    logic          out;
    logic          has;
    logic [7:0]    sym;
    logic [AW-1:0] child;
    logic [AW-1:0] sib;
    logic [AW-1:0] fail;
  } node_t;

  localparam int NW = $bits(node_t);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_INS_RD, S_INS_CHK, S_INS_WR2, S_INS_END,
    S_OUT_RD, S_OUT_CHK,
    S_W_RD, S_W_CHK, S_T_RD, S_T_CHK,
    S_B0_RD, S_B0_CHK, S_BQ, S_BH, S_BN_RD, S_BN_CHK, S_BN_NEXT,
    S_Q_RD, S_Q_CHK, S_RES
  } state_t;

  typedef enum logic [2:0] {P_PAT, P_END, P_TXT, P_EOL, P_BLD} purpose_t;

  state_t   state;
  purpose_t purpose;
  logic [AW-1:0] n, c, t, q, nsib, cfail, head_fail, rd_addr, cur, ins;
  logic [7:0] zsym;
  logic hd, bhd, rout, ins_ok, failed_seen, match_all, ovf, dropped, wl, res_m;
  logic [1:0] decided;
  logic [AW:0] nfree, rear, front;

  node_t d, mem_wdata;
  logic [NW-1:0] mem_rdata;
  logic mem_we, q_we;
  logic [AW-1:0] mem_waddr, q_rdata;
  logic hit, can_enq;
  logic [AW-1:0] hf;

  assign d = node_t'(mem_rdata);
  assign hit = d.has && (d.sym == zsym);
  assign hf = hd ? d.fail : cfail;
  assign can_enq = rear < NODE_CNT;
  assign item_stall = (state != S_IDLE);

  mpbm_ram #(.DEPTH(NODE_COUNT), .WIDTH(NW)) u_nodes (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(NW'(mem_wdata)),
    .raddr(rd_addr), .rdata(mem_rdata)
  );

  mpbm_ram #(.DEPTH(NODE_COUNT), .WIDTH(AW)) u_queue (
    .clk(clk), .we(q_we), .waddr(rear[AW-1:0]), .wdata(d.child),
    .raddr(front[AW-1:0]), .rdata(q_rdata)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = n;
    mem_wdata = '0;
    q_we = 1'b0;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_INS_CHK: begin
        mem_wdata = d;
        if (!hit && !d.has && nfree < NODE_CNT) begin
          mem_we = 1'b1;
          mem_wdata.has = 1'b1;
          mem_wdata.sym = zsym;
          mem_wdata.child = nfree[AW-1:0];
        end else if (!hit && d.has && d.sib == '0 &&
                     (nfree + (AW + 1)'(2)) <= NODE_CNT) begin
          mem_we = 1'b1;
          mem_wdata.sib = nfree[AW-1:0];
        end
      end
      S_INS_WR2: begin
        mem_we = 1'b1;
        mem_wdata.has = 1'b1;
        mem_wdata.sym = zsym;
        mem_wdata.child = t;
      end
      S_OUT_CHK: begin
        mem_we = 1'b1;
        mem_waddr = t;
        mem_wdata = d;
        mem_wdata.out = 1'b1;
      end
      S_Q_CHK: begin
        mem_we = 1'b1;
        mem_waddr = q;
        mem_wdata = d;
        mem_wdata.fail = t;
        mem_wdata.out = d.out | rout;
      end
      S_B0_CHK, S_BN_CHK: begin
        q_we = d.has && can_enq;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      wl <= 1'b0;
      result_valid <= 1'b0;
      n <= '0;
      rd_addr <= '0;
      nfree <= (AW + 1)'(1);
      ins <= '0;
      cur <= '0;
      failed_seen <= 1'b0;
      decided <= mpbm_pkg::UNDECIDED;
      match_all <= 1'b0;
      ovf <= 1'b0;
      dropped <= 1'b0;
      rear <= '0;
      front <= '0;
      purpose <= P_PAT;
      hd <= 1'b0;
      bhd <= 1'b0;
    end else begin
      if (whole_line_write) begin
        wl <= whole_line;
      end
      if (state == S_RES && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          n <= n + 1'b1;
          if (n == AW'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            zsym <= (cmd == mpbm_pkg::CMD_EOL) ? mpbm_pkg::WORD_END : byte_value;
            case (cmd)
              mpbm_pkg::CMD_CLEAR: begin
                state <= S_CLR;
                n <= '0;
                nfree <= (AW + 1)'(1);
                ins <= '0;
                match_all <= 1'b0;
                ovf <= 1'b0;
                dropped <= 1'b0;
                cur <= '0;
                failed_seen <= 1'b0;
                decided <= mpbm_pkg::UNDECIDED;
              end
              mpbm_pkg::CMD_PATTERN: begin
                if (byte_value == mpbm_pkg::WORD_END) begin
                  if (dropped) begin
                    ins <= '0;
                    dropped <= 1'b0;
                  end else if (wl) begin
                    purpose <= P_END;
                    n <= ins;
                    rd_addr <= ins;
                    state <= S_INS_RD;
                  end else if (ins == '0) begin
                    match_all <= 1'b1;
                  end else begin
                    t <= ins;
                    rd_addr <= ins;
                    state <= S_OUT_RD;
                  end
                end else if (!dropped) begin
                  purpose <= P_PAT;
                  n <= ins;
                  rd_addr <= ins;
                  state <= S_INS_RD;
                end
              end
              mpbm_pkg::CMD_BUILD: begin
                ins <= '0;
                dropped <= 1'b0;
                purpose <= P_BLD;
                n <= '0;
                rd_addr <= '0;
                rear <= '0;
                front <= '0;
                state <= S_B0_RD;
              end
              mpbm_pkg::CMD_TEXT: begin
                if (decided == mpbm_pkg::UNDECIDED) begin
                  purpose <= P_TXT;
                  c <= cur;
                  n <= cur;
                  hd <= 1'b1;
                  rd_addr <= cur;
                  state <= S_W_RD;
                end
              end
              mpbm_pkg::CMD_EOL: begin
                if (match_all) begin
                  res_m <= 1'b1;
                  state <= S_RES;
                end else if (decided != mpbm_pkg::UNDECIDED) begin
                  res_m <= (decided == mpbm_pkg::DECIDED_MATCH);
                  state <= S_RES;
                end else begin
                  purpose <= P_EOL;
                  c <= cur;
                  n <= cur;
                  hd <= 1'b1;
                  rd_addr <= cur;
                  state <= S_W_RD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_INS_RD: begin
          state <= S_INS_CHK;
        end
        S_INS_CHK: begin
          if (hit) begin
            t <= d.child;
            ins_ok <= 1'b1;
            state <= S_INS_END;
          end else if (!d.has) begin
            ins_ok <= nfree < NODE_CNT;
            t <= nfree[AW-1:0];
            if (nfree < NODE_CNT) begin
              nfree <= nfree + 1'b1;
            end
            state <= S_INS_END;
          end else if (d.sib == '0) begin
            ins_ok <= (nfree + (AW + 1)'(2)) <= NODE_CNT;
            if ((nfree + (AW + 1)'(2)) <= NODE_CNT) begin
              n <= nfree[AW-1:0];
              t <= nfree[AW-1:0] + 1'b1;
              nfree <= nfree + (AW + 1)'(2);
              state <= S_INS_WR2;
            end else begin
              state <= S_INS_END;
            end
          end else begin
            n <= d.sib;
            rd_addr <= d.sib;
            state <= S_INS_RD;
          end
        end
        S_INS_WR2: begin
          state <= S_INS_END;
        end
        S_INS_END: begin
          if (ins_ok) begin
            if (purpose == P_PAT) begin
              ins <= t;
              state <= S_IDLE;
            end else begin
              rd_addr <= t;
              state <= S_OUT_RD;
            end
          end else begin
            ovf <= 1'b1;
            state <= S_IDLE;
            if (purpose == P_PAT) begin
              dropped <= 1'b1;
            end else begin
              ins <= '0;
              dropped <= 1'b0;
            end
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_CHK;
        end
        S_OUT_CHK: begin
          ins <= '0;
          dropped <= 1'b0;
          state <= S_IDLE;
        end
        S_W_RD: begin
          state <= S_W_CHK;
        end
        S_W_CHK: begin
          if (hd) begin
            cfail <= d.fail;
          end
          if (hit) begin
            hd <= 1'b0;
            t <= d.child;
            rd_addr <= d.child;
            state <= S_T_RD;
          end else if (d.sib != '0) begin
            hd <= 1'b0;
            n <= d.sib;
            rd_addr <= d.sib;
            state <= S_W_RD;
          end else begin
            if (purpose != P_BLD) begin
              failed_seen <= 1'b1;
            end
            if (c == '0) begin
              hd <= 1'b0;
              t <= '0;
              rd_addr <= '0;
              state <= S_T_RD;
            end else begin
              c <= hf;
              n <= hf;
              hd <= 1'b1;
              rd_addr <= hf;
              state <= S_W_RD;
            end
          end
        end
        S_T_RD: begin
          state <= S_T_CHK;
        end
        S_T_CHK: begin
          case (purpose)
            P_TXT: begin
              cur <= t;
              if (d.out) begin
                decided <= wl ? mpbm_pkg::DECIDED_MISS : mpbm_pkg::DECIDED_MATCH;
              end
              state <= S_IDLE;
            end
            P_EOL: begin
              res_m <= d.out && !(wl && failed_seen);
              state <= S_RES;
            end
            default: begin
              rout <= d.out;
              rd_addr <= q;
              state <= S_Q_RD;
            end
          endcase
        end
        S_B0_RD: begin
          state <= S_B0_CHK;
        end
        S_B0_CHK: begin
          if (d.has && can_enq) begin
            rear <= rear + 1'b1;
          end
          if (d.sib == '0) begin
            state <= S_BQ;
          end else begin
            n <= d.sib;
            rd_addr <= d.sib;
            state <= S_B0_RD;
          end
        end
        S_BQ: begin
          if (front < rear) begin
            front <= front + 1'b1;
            state <= S_BH;
          end else begin
            cur <= '0;
            failed_seen <= 1'b0;
            decided <= mpbm_pkg::UNDECIDED;
            state <= S_IDLE;
          end
        end
        S_BH: begin
          n <= q_rdata;
          bhd <= 1'b1;
          rd_addr <= q_rdata;
          state <= S_BN_RD;
        end
        S_BN_RD: begin
          state <= S_BN_CHK;
        end
        S_BN_CHK: begin
          if (bhd) begin
            head_fail <= d.fail;
          end
          bhd <= 1'b0;
          nsib <= d.sib;
          if (d.has) begin
            if (can_enq) begin
              rear <= rear + 1'b1;
            end
            zsym <= d.sym;
            q <= d.child;
            c <= bhd ? d.fail : head_fail;
            n <= bhd ? d.fail : head_fail;
            rd_addr <= bhd ? d.fail : head_fail;
            hd <= 1'b1;
            state <= S_W_RD;
          end else begin
            state <= S_BN_NEXT;
          end
        end
        S_Q_RD: begin
          state <= S_Q_CHK;
        end
        S_Q_CHK: begin
          state <= S_BN_NEXT;
        end
        S_BN_NEXT: begin
          if (nsib == '0) begin
            state <= S_BQ;
          end else begin
            n <= nsib;
            rd_addr <= nsib;
            state <= S_BN_RD;
          end
        end
        S_RES: begin
          if (!result_valid || !result_stall) begin
            line_match <= res_m;
            table_full <= ovf;
            cur <= '0;
            failed_seen <= 1'b0;
            decided <= mpbm_pkg::UNDECIDED;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_nfree_bound: assert property (@(posedge clk) disable iff (rst)
    nfree <= NODE_CNT && nfree != '0)
    else $error("node allocation past store size");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    front <= rear && rear <= NODE_CNT)
    else $error("queue front passed rear");

  a_result_from_res: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_RES))
    else $error("result loaded outside result state");

  a_decided_code: assert property (@(posedge clk) disable iff (rst)
    decided != 2'd3)
    else $error("bad line decision code");

endmodule

[tb/line_match_checker.sv]
`timescale 1ns / 100ps
// line_match_checker: watches the item, result and whole_line channels of the matcher,
// runs its own trie automaton and compares every end-of-line result; depends on mpbm_pkg
module line_match_checker #(
  parameter int NODE_COUNT = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_stall,
  input  logic [2:0] cmd,
  input  logic [7:0] byte_value,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic       line_match,
  input  logic       table_full,
  input  logic       whole_line_write,
  input  logic       whole_line,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic match;
    logic full;
  } verdict_t;

  typedef struct {
    logic [7:0] sym;
    logic       has_sym;
    logic       out;
    int         child;
    int         sib;
    int         fail;
  } trie_node_t;

  trie_node_t nodes[NODE_COUNT];
  int         bfs[NODE_COUNT];
  int         free_node, ins_pos, cur_node;
  logic       failed_seen, match_all, overflowed, word_dropped, mode_whole;
  logic [1:0] decided;
  verdict_t   verdicts[$];

  assign pending = verdicts.size();

  function automatic int wrap(int v);
    return (v >= 0 && v < NODE_COUNT) ? v : 0;
  endfunction

  function automatic bit find_edge(int head, logic [7:0] s, output int tgt);
    int n;
    n = wrap(head);
    tgt = 0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (nodes[n].has_sym && nodes[n].sym == s) begin
        tgt = wrap(nodes[n].child);
        return 1;
      end
      if (nodes[n].sib == 0) return 0;
      n = wrap(nodes[n].sib);
    end
    return 0;
  endfunction

  function automatic bit insert_edge(int head, logic [7:0] s, output int tgt);
    int n, e, k;
    n = wrap(head);
    tgt = 0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (nodes[n].has_sym && nodes[n].sym == s) begin
        tgt = wrap(nodes[n].child);
        return 1;
      end
      if (!nodes[n].has_sym) begin
        if (free_node >= NODE_COUNT) return 0;
        k = free_node++;
        nodes[n].sym = s;
        nodes[n].has_sym = 1;
        nodes[n].child = k;
        tgt = k;
        return 1;
      end
      if (nodes[n].sib == 0) begin
        if (free_node + 2 > NODE_COUNT) return 0;
        e = free_node++;
        k = free_node++;
        nodes[n].sib = e;
        nodes[e].sym = s;
        nodes[e].has_sym = 1;
        nodes[e].child = k;
        tgt = k;
        return 1;
      end
      n = wrap(nodes[n].sib);
    end
    return 0;
  endfunction

  function automatic void restart_line();
    cur_node = 0;
    failed_seen = 0;
    decided = mpbm_pkg::UNDECIDED;
  endfunction

  function automatic void clear_trie();
    foreach (nodes[i]) nodes[i] = '{8'd0, 1'b0, 1'b0, 0, 0, 0};
    free_node = 1;
    ins_pos = 0;
    match_all = 0;
    overflowed = 0;
    word_dropped = 0;
    restart_line();
  endfunction

  function automatic void add_pattern_byte(logic [7:0] b);
    int t;
    if (b == mpbm_pkg::WORD_END) begin
      if (!word_dropped) begin
        if (mode_whole) begin
          if (insert_edge(ins_pos, mpbm_pkg::WORD_END, t)) nodes[t].out = 1;
          else overflowed = 1;
        end else if (ins_pos == 0) begin
          match_all = 1;
        end else begin
          nodes[wrap(ins_pos)].out = 1;
        end
      end
      ins_pos = 0;
      word_dropped = 0;
      return;
    end
    if (word_dropped) return;
    if (insert_edge(ins_pos, b, t)) begin
      ins_pos = t;
    end else begin
      overflowed = 1;
      word_dropped = 1;
    end
  endfunction

  function automatic void build_failure_links();
    int front, rear, n, hd, hf, q, st, res, t;
    front = 0;
    rear = 0;
    n = 0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      if (nodes[n].has_sym && rear < NODE_COUNT) bfs[rear++] = wrap(nodes[n].child);
      if (nodes[n].sib == 0) break;
      n = wrap(nodes[n].sib);
    end
    while (front < rear) begin
      hd = bfs[front++];
      hf = wrap(nodes[hd].fail);
      n = hd;
      for (int i = 0; i < NODE_COUNT; i++) begin
        if (nodes[n].has_sym) begin
          q = wrap(nodes[n].child);
          st = hf;
          res = 0;
          if (rear < NODE_COUNT) bfs[rear++] = q;
          for (int j = 0; j <= NODE_COUNT; j++) begin
            if (find_edge(st, nodes[n].sym, t)) begin
              res = t;
              break;
            end
            if (st == 0) break;
            st = wrap(nodes[st].fail);
          end
          nodes[q].fail = res;
          if (res != 0 && nodes[res].out) nodes[q].out = 1;
        end
        if (nodes[n].sib == 0) break;
        n = wrap(nodes[n].sib);
      end
    end
  endfunction

  function automatic int step_state(int c, logic [7:0] z);
    int t;
    c = wrap(c);
    for (int i = 0; i <= NODE_COUNT; i++) begin
      if (find_edge(c, z, t)) return t;
      failed_seen = 1;
      if (c == 0) return 0;
      c = wrap(nodes[c].fail);
    end
    return 0;
  endfunction

  function automatic void predict_transfer(logic [2:0] c, logic [7:0] b);
    verdict_t v;
    case (c)
      mpbm_pkg::CMD_CLEAR: clear_trie();
      mpbm_pkg::CMD_PATTERN: add_pattern_byte(b);
      mpbm_pkg::CMD_BUILD: begin
        ins_pos = 0;
        word_dropped = 0;
        build_failure_links();
        restart_line();
      end
      mpbm_pkg::CMD_TEXT: begin
        if (decided == mpbm_pkg::UNDECIDED) begin
          cur_node = step_state(cur_node, b);
          if (nodes[cur_node].out)
            decided = mode_whole ? mpbm_pkg::DECIDED_MISS : mpbm_pkg::DECIDED_MATCH;
        end
      end
      mpbm_pkg::CMD_EOL: begin
        if (match_all) begin
          v.match = 1;
        end else if (decided != mpbm_pkg::UNDECIDED) begin
          v.match = (decided == mpbm_pkg::DECIDED_MATCH);
        end else begin
          cur_node = step_state(cur_node, mpbm_pkg::WORD_END);
          v.match = nodes[cur_node].out && !(mode_whole && failed_seen);
        end
        v.full = overflowed;
        verdicts.push_back(v);
        restart_line();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      mode_whole <= 0;
      clear_trie();
      verdicts.delete();
      fail_count <= 0;
    end else begin
      if (whole_line_write) mode_whole <= whole_line;
      if (result_valid && !result_stall) begin
        if (verdicts.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer at %0t", $time);
          fail_count <= fail_count + 1;
        end else begin
          want = verdicts.pop_front();
          if (want.match !== line_match || want.full !== table_full) begin
            if (fail_count < 10)
              $display("mismatch at %0t: line_match exp %0b got %0b, table_full exp %0b got %0b",
                       $time, want.match, line_match, want.full, table_full);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (item_valid && !item_stall) predict_transfer(cmd, byte_value);
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// testbench: drives command streams and stall patterns into multi_pattern_byte_matcher
// depends on mpbm_pkg, the matcher RTL and line_match_checker
module testbench;

  logic       clk, rst;
  logic       item_valid, item_stall;
  logic [2:0] cmd;
  logic [7:0] byte_value;
  logic       result_valid, result_stall;
  logic       line_match, table_full;
  logic       whole_line_write, whole_line;
  int         fail_count, pending;
  int         send_idle, recv_idle;
  bit         hold_off;

  multi_pattern_byte_matcher DUT (.*);

  line_match_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("TB_ERROR");
    $finish;
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) result_stall <= 0;
    else result_stall <= hold_off || ($urandom_range(99) < recv_idle);
  end

  task automatic send(logic [2:0] c, logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    cmd <= c;
    byte_value <= b;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_word(string w);
    foreach (w[i]) send(mpbm_pkg::CMD_PATTERN, w[i]);
    send(mpbm_pkg::CMD_PATTERN, mpbm_pkg::WORD_END);
  endtask

  task automatic send_line(string w);
    foreach (w[i]) send(mpbm_pkg::CMD_TEXT, w[i]);
    send(mpbm_pkg::CMD_EOL, 8'd0);
  endtask

  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (pending != 0 || item_stall) @(posedge clk);
  endtask

  task automatic drain_and_set(logic mode);
    drain();
    whole_line_write <= 1;
    whole_line <= mode;
    @(posedge clk);
    whole_line_write <= 0;
  endtask

  function automatic logic [7:0] rand_sym();
    return $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(8'h63, 8'h61));
  endfunction

  task automatic random_phase(int n_items);
    int k, len;
    k = 0;
    while (k < n_items) begin
      case ($urandom_range(9))
        0: begin
          send(mpbm_pkg::CMD_CLEAR, 8'($urandom));
          k++;
        end
        1, 2: begin
          len = $urandom_range(5);
          for (int i = 0; i < len; i++) send(mpbm_pkg::CMD_PATTERN, rand_sym());
          send(mpbm_pkg::CMD_PATTERN, mpbm_pkg::WORD_END);
          k += len + 1;
        end
        3: begin
          send(mpbm_pkg::CMD_BUILD, 8'($urandom));
          k++;
        end
        4: begin
          send(3'($urandom_range(7, 5)), 8'($urandom));
          k++;
        end
        default: begin
          len = $urandom_range(8);
          for (int i = 0; i < len; i++) send(mpbm_pkg::CMD_TEXT, rand_sym());
          send(mpbm_pkg::CMD_EOL, 8'($urandom));
          k += len + 1;
        end
      endcase
    end
  endtask

  initial begin
    rst = 1;
    item_valid = 0;
    cmd = mpbm_pkg::CMD_CLEAR;
    byte_value = 0;
    whole_line_write = 0;
    whole_line = 0;
    hold_off = 0;
    send_idle = 6;
    recv_idle = 79;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: text before build, words, build, lines, odd bytes
    send_line("ab");
    send_word("he");
    send_word("she");
    send_word("his");
    send(mpbm_pkg::CMD_BUILD, 8'hff);
    send_line("ushe");
    send_line("hi");
    send(mpbm_pkg::CMD_TEXT, 8'hff);
    send(mpbm_pkg::CMD_TEXT, 8'h00);
    send(mpbm_pkg::CMD_TEXT, mpbm_pkg::WORD_END);
    send(mpbm_pkg::CMD_EOL, 8'hff);
    send(3'd5, 8'h00);
    send(3'd7, 8'hff);
    send_word("");
    send_line("x");
    send(mpbm_pkg::CMD_CLEAR, 8'h00);
    drain_and_set(1);
    send_word("ab");
    send_word("");
    send(mpbm_pkg::CMD_PATTERN, 8'h61);
    send(mpbm_pkg::CMD_BUILD, 8'h00);
    send_line("ab");
    send_line("xab");
    send_line("abc");
    send_line("");

    // fill the store so words are dropped
    for (int i = 0; i < 1100; i++) send(mpbm_pkg::CMD_PATTERN, 8'h41);
    send(mpbm_pkg::CMD_PATTERN, mpbm_pkg::WORD_END);
    send_word("zz");
    send_line("zz");

    // long receiver hold-off while end-of-line items keep being offered
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      begin
        for (int i = 0; i < 12; i++) send(mpbm_pkg::CMD_EOL, 8'd0);
        item_valid <= 0;
      end
    join

    drain_and_set(0);
    send(mpbm_pkg::CMD_CLEAR, 8'd0);
    random_phase(210);
    drain_and_set(1);
    send_idle = 79;
    recv_idle = 6;
    random_phase(210);
    drain_and_set(0);
    send_idle = 0;
    recv_idle = 0;
    random_phase(210);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
